// File: src/bba_pkg.sv
// bba_pkg: shared widths, command/status codes, register indexes and reset values
// for the block bitmap allocator; no dependencies
`timescale 1ns / 1ps

package bba_pkg;

	// field widths
	localparam int CMD_W     = 2;
	localparam int BN_W      = 16;
	localparam int BASE_W    = 8;
	localparam int COUNT_W   = 13;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	// request commands
	localparam logic [CMD_W-1:0] CMD_FIND        = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MARK_USED   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK_UNUSED = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TEST        = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

	// register reset values
	localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

endpackage

// File: src/bba_req_if.sv
// bba_req_if: request channel (command and block number) with valid/ready
// depends on bba_pkg for field widths
`timescale 1ns / 1ps

interface bba_req_if;
	logic                       valid;
	logic                       ready;
	logic [bba_pkg::CMD_W-1:0]  command;
	logic [bba_pkg::BN_W-1:0]   block_number;

	modport source (output valid, output command, output block_number, input ready);
	modport sink   (input valid, input command, input block_number, output ready);
endinterface

// File: src/bba_rsp_if.sv
// bba_rsp_if: result channel (found block, used bit, status) with valid/ready
// depends on bba_pkg for field widths
`timescale 1ns / 1ps

interface bba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bba_pkg::BN_W-1:0]     found_block;
	logic                         is_used;
	logic [bba_pkg::STATUS_W-1:0] status;

	modport source (output valid, output found_block, output is_used, output status,
		input ready);
	modport sink   (input valid, input found_block, input is_used, input status,
		output ready);
endinterface

// File: src/block_bitmap_allocator.sv
// Free-block bitmap allocator. One used/free bit per block sits in a single-port-read
// synchronous RAM of ceil(MAX_BLOCKS/WORD_BITS) words. After reset the RAM is cleared one
// word a cycle, and no request is taken until the last word is cleared; configuration
// writes are taken throughout. One request is worked at a time. Mark-used and mark-unused
// do a read-modify-write of one word and test only reads it: the word index comes from
// a reciprocal multiply (S_DIV), the word is read (S_READ), modified and written back
// (S_RMW), and the result goes to the output register (S_DONE); out-of-range numbers go
// straight to S_DONE. Find-free reads one word per cycle from the lowest address and
// stops at the first word with a clear bit; S_FIND turns its position into a block
// number, or a no-free status if it lies at or past the block count; when every word
// read is full the scan goes to S_DONE with no-free. A new request is taken as soon as
// the previous result sits in the output register, even if it has not been taken yet.
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_zero_find
`timescale 1ns / 1ps

module block_bitmap_allocator #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
	bba_req_if.sink                         req,
	bba_rsp_if.source                       rsp
);

	localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int SPAN  = WORDS * WORD_BITS;
	localparam int SW    = $clog2(SPAN + 1);
	localparam int EW    = (SW > bba_pkg::BN_W + 1) ? SW : bba_pkg::BN_W + 1;
	localparam int S     = EW + BW;
	localparam logic [S:0]    RECIP = (S + 1)'((2 ** S + WORD_BITS - 1) / WORD_BITS);
	localparam logic [EW-1:0] WB    = EW'(WORD_BITS);
	localparam logic [EW-1:0] MAXB  = EW'(MAX_BLOCKS);

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_RMW   = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_FIND  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                        state_q;
	logic [AW-1:0]                     clr_addr_q;
	logic [bba_pkg::BASE_W-1:0]        base_q;
	logic [bba_pkg::COUNT_W-1:0]       count_q;

	logic [bba_pkg::CMD_W-1:0]         cmd_q;
	logic [EW-1:0]                     off_q;
	logic [AW-1:0]                     q_q;
	logic [BW-1:0]                     bit_q;
	logic [AW:0]                       ra_q;
	logic                              chk_v_q;
	logic                              chk_last_q;
	logic [EW-1:0]                     chk_base_q;
	logic [EW-1:0]                     idx_q;

	logic [bba_pkg::BN_W-1:0]          res_found_q;
	logic                              res_used_q;
	logic [bba_pkg::STATUS_W-1:0]      res_status_q;

	logic                              out_v_q;
	logic [bba_pkg::BN_W-1:0]          out_found_q;
	logic                              out_used_q;
	logic [bba_pkg::STATUS_W-1:0]      out_status_q;

	logic [WORD_BITS-1:0]              mem [0:WORDS-1];
	logic [WORD_BITS-1:0]              rd_data_s1;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic [WORD_BITS-1:0]              wr_data;

	logic [EW-1:0]                     cnt_eff;
	logic [EW-1:0]                     base_ext;
	logic [EW-1:0]                     bn_ext;
	logic [EW-1:0]                     in_off;
	logic                              in_bad;
	logic                              req_take;
	logic                              out_free;
	logic [EW+S-1:0]                   div_prod;
	logic [EW-1:0]                     word_start;
	logic [EW-1:0]                     rem;
	logic                              scan_issue;
	logic                              zf_hit;
	logic [BW-1:0]                     zf_pos;
	logic [EW-1:0]                     find_sum;
	logic [WORD_BITS-1:0]              bit_mask;

	// effective count, capped at MAX_BLOCKS
	assign cnt_eff  = (EW'(count_q) > MAXB) ? MAXB : EW'(count_q);
	assign base_ext = EW'(base_q);
	assign bn_ext   = EW'(req.block_number);
	assign in_off   = bn_ext - base_ext;
	assign in_bad   = (bn_ext < base_ext) || (in_off >= cnt_eff);

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;

	// word and bit of the offset: reciprocal multiply, then remainder
	assign div_prod   = (EW + S)'(off_q) * (EW + S)'(RECIP);
	assign word_start = EW'(q_q) * WB;
	assign rem        = off_q - word_start;
	assign bit_mask   = WORD_BITS'(1) << bit_q;

	// scan read issue while words remain
	assign scan_issue = (state_q == S_SCAN) && (ra_q < (AW + 1)'(WORDS));

	assign find_sum = idx_q + base_ext;

	bba_zero_find #(
		.WORD_BITS(WORD_BITS)
	) u_zero_find (
		.word(rd_data_s1),
		.hit (zf_hit),
		.pos (zf_pos)
	);

	// ram port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = q_q;
		wr_en   = 1'b0;
		wr_addr = q_q;
		wr_data = rd_data_s1;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			S_READ: begin
				rd_en = 1'b1;
			end
			S_SCAN: begin
				rd_en   = scan_issue;
				rd_addr = ra_q[AW-1:0];
			end
			S_RMW: begin
				if (cmd_q == bba_pkg::CMD_MARK_USED) begin
					wr_en   = 1'b1;
					wr_data = rd_data_s1 | bit_mask;
				end else if (cmd_q == bba_pkg::CMD_MARK_UNUSED) begin
					wr_en   = 1'b1;
					wr_data = rd_data_s1 & ~bit_mask;
				end
			end
			default: begin
			end
		endcase
	end

	// bitmap ram, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= bba_pkg::BASE_RESET;
			count_q <= bba_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bba_pkg::CFG_DATA_BASE:   base_q  <= cfg_data[bba_pkg::BASE_W-1:0];
				bba_pkg::CFG_BLOCK_COUNT: count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			ra_q       <= '0;
			chk_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_DONE) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_addr_q == AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req_take) begin
						ra_q    <= '0;
						chk_v_q <= 1'b0;
						if (req.command == bba_pkg::CMD_FIND) begin
							state_q <= S_SCAN;
						end else if (in_bad) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV:  state_q <= S_READ;
				S_READ: state_q <= S_RMW;
				S_RMW:  state_q <= S_DONE;
				S_SCAN: begin
					if (scan_issue) begin
						ra_q <= ra_q + (AW + 1)'(1);
					end
					chk_v_q <= scan_issue;
					if (chk_v_q && zf_hit) begin
						state_q <= S_FIND;
					end else if (chk_v_q && chk_last_q) begin
						state_q <= S_DONE;
					end
				end
				S_FIND: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q        <= req.command;
				off_q        <= in_off;
				chk_base_q   <= '0;
				res_found_q  <= '0;
				res_used_q   <= 1'b0;
				res_status_q <= bba_pkg::STAT_RANGE;
			end
			S_DIV: begin
				q_q <= div_prod[S +: AW];
			end
			S_READ: begin
				bit_q <= rem[BW-1:0];
			end
			S_RMW: begin
				res_status_q <= bba_pkg::STAT_OK;
				res_used_q   <= (cmd_q == bba_pkg::CMD_TEST) && rd_data_s1[bit_q];
			end
			S_SCAN: begin
				if (scan_issue) begin
					chk_last_q <= (ra_q == (AW + 1)'(WORDS - 1));
				end
				if (chk_v_q) begin
					chk_base_q <= chk_base_q + WB;
					idx_q      <= chk_base_q + EW'(zf_pos);
				end
				res_status_q <= bba_pkg::STAT_NO_FREE;
			end
			S_FIND: begin
				if (idx_q >= cnt_eff) begin
					res_status_q <= bba_pkg::STAT_NO_FREE;
				end else begin
					res_status_q <= bba_pkg::STAT_OK;
					res_found_q  <= find_sum[bba_pkg::BN_W-1:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_found_q  <= res_found_q;
					out_used_q   <= res_used_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_v_q;
	assign rsp.found_block = out_found_q;
	assign rsp.is_used     = out_used_q;
	assign rsp.status      = out_status_q;

`ifndef SYNTH
	// a find never writes the bitmap
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !wr_en)
		else $error("bitmap written during find scan");

	// out-of-range results carry no block and no used bit
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == bba_pkg::STAT_RANGE) |->
		(rsp.found_block == '0 && !rsp.is_used))
		else $error("out-of-range result with payload");

	// no-free results carry no block number
	a_nofree_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == bba_pkg::STAT_NO_FREE) |-> (rsp.found_block == '0))
		else $error("no-free result with block number");

	// a used bit is only reported with ok status
	a_used_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.is_used) |-> (rsp.status == bba_pkg::STAT_OK))
		else $error("used bit with error status");
`endif

endmodule

// File: src/bba_zero_find.sv
// bba_zero_find: lowest clear bit of one bitmap word
// no dependencies
`timescale 1ns / 1ps

module bba_zero_find #(
	parameter int WORD_BITS = 64
) (
	input  logic [WORD_BITS-1:0]         word,
	output logic                         hit,
	output logic [$clog2(WORD_BITS)-1:0] pos
);

	localparam int BW = $clog2(WORD_BITS);

	// any clear bit at all
	assign hit = ~&word;

	// priority encode, lowest clear bit wins
	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				pos = BW'(i);
			end
		end
	end

endmodule

// File: bench/tb_block_bitmap_allocator.sv
// tb_block_bitmap_allocator: self-checking bench for the block bitmap allocator
// depends on bba_pkg, bba_req_if, bba_rsp_if and block_bitmap_allocator
`timescale 1ns / 1ps

module tb_block_bitmap_allocator;

	localparam int MAX_BLOCKS  = 4096;
	localparam int CLK_HALF    = 6;
	localparam int SETTLE      = 8;
	localparam int END_CYCLES  = 80;
	localparam int BLOCK_ITEMS = 40;
	localparam int FILL_BITS   = 128;

	typedef struct packed {
		logic [bba_pkg::BN_W-1:0]     found_block;
		logic                         is_used;
		logic [bba_pkg::STATUS_W-1:0] status;
	} alloc_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bba_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bba_pkg::CFG_W-1:0]     cfg_data;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	block_bitmap_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	// shadow of the bitmap and the registers
	logic [MAX_BLOCKS-1:0]       shadow_map;
	logic [bba_pkg::BASE_W-1:0]  base_reg;
	logic [bba_pkg::COUNT_W-1:0] count_reg;

	alloc_result_t pending_results[$];
	int            allocated[$];
	int            idle_pct;
	int            stall_pct;
	int            errors;
	int            requests_sent;
	int            finds_sent;
	int            results_checked;
	int            config_writes;

	// allocatable bits: the count capped at storage size
	function automatic int usable_count();
		return (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_reg);
	endfunction

	// apply one request to the shadow bitmap and return its result
	function automatic alloc_result_t apply_request(input logic [bba_pkg::CMD_W-1:0] cmd,
		input logic [bba_pkg::BN_W-1:0] bn);
		alloc_result_t r;
		int            cnt;
		int            idx;
		r = '0;
		cnt = usable_count();
		if (cmd == bba_pkg::CMD_FIND) begin
			idx = MAX_BLOCKS;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				if (!shadow_map[i]) begin
					idx = i;
					break;
				end
			end
			if (idx >= cnt)
				r.status = bba_pkg::STAT_NO_FREE;
			else
				r.found_block = bba_pkg::BN_W'(idx + int'(base_reg));
		end else if (bn < base_reg || int'(bn) - int'(base_reg) >= cnt) begin
			r.status = bba_pkg::STAT_RANGE;
		end else begin
			idx = int'(bn) - int'(base_reg);
			case (cmd)
				bba_pkg::CMD_MARK_USED:   shadow_map[idx] = 1'b1;
				bba_pkg::CMD_MARK_UNUSED: shadow_map[idx] = 1'b0;
				default:                  r.is_used = shadow_map[idx];
			endcase
		end
		return r;
	endfunction

	// offer one request, predict its result once it is taken
	task automatic send_request(input logic [bba_pkg::CMD_W-1:0] cmd,
		input logic [bba_pkg::BN_W-1:0] bn, output alloc_result_t predicted);
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.block_number <= bn;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_request(cmd, bn);
		pending_results.push_back(predicted);
		requests_sent++;
		if (cmd == bba_pkg::CMD_FIND)
			finds_sent++;
	endtask

	// drop valid and wait until every result is back
	task automatic wait_idle(input int settle);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic set_config(input logic [bba_pkg::BASE_W-1:0] base,
		input logic [bba_pkg::COUNT_W-1:0] count);
		logic [bba_pkg::CFG_W-1:0] noise;
		wait_idle(SETTLE);
		noise = bba_pkg::CFG_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= bba_pkg::CFG_DATA_BASE;
		cfg_data  <= {noise[bba_pkg::CFG_W-1:bba_pkg::BASE_W], base};
		@(posedge clk);
		cfg_index <= bba_pkg::CFG_BLOCK_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_reg = base;
		count_reg = count;
		config_writes++;
		allocated.delete();
		@(posedge clk);
	endtask

	// block number at or near the edges of the valid range, or anywhere in it
	function automatic logic [bba_pkg::BN_W-1:0] edge_number();
		int cnt;
		cnt = usable_count();
		case ($urandom_range(4))
			0:       return bba_pkg::BN_W'(int'(base_reg) - 1);
			1:       return bba_pkg::BN_W'(base_reg);
			2:       return bba_pkg::BN_W'(int'(base_reg) + cnt - 1);
			3:       return bba_pkg::BN_W'(int'(base_reg) + cnt);
			default: return bba_pkg::BN_W'(int'(base_reg) + $urandom_range(cnt));
		endcase
	endfunction

	function automatic logic [bba_pkg::BASE_W-1:0] pick_base();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return bba_pkg::BASE_W'($urandom);
		endcase
	endfunction

	// mostly small counts so the range fills up, with the extremes mixed in
	function automatic logic [bba_pkg::COUNT_W-1:0] pick_count();
		case ($urandom_range(9))
			0:       return '0;
			1:       return bba_pkg::COUNT_W'(1);
			2:       return bba_pkg::COUNT_W'(64);
			3:       return bba_pkg::COUNT_W'(65);
			4:       return bba_pkg::COUNT_W'(MAX_BLOCKS);
			5:       return bba_pkg::COUNT_W'($urandom_range(8191, MAX_BLOCKS + 1));
			6:       return bba_pkg::COUNT_W'($urandom_range(8191));
			default: return bba_pkg::COUNT_W'($urandom_range(300, 2));
		endcase
	endfunction

	task automatic test_after_reset();
		alloc_result_t r;
		send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		send_request(bba_pkg::CMD_TEST, 16'd0, r);
		send_request(bba_pkg::CMD_MARK_USED, 16'd1, r);
		send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		send_request(bba_pkg::CMD_TEST, 16'd4096, r);
		send_request(bba_pkg::CMD_MARK_USED, 16'd4096, r);
		send_request(bba_pkg::CMD_TEST, 16'd4096, r);
		send_request(bba_pkg::CMD_TEST, 16'd4097, r);
		send_request(bba_pkg::CMD_MARK_UNUSED, 16'hFFFF, r);
		send_request(bba_pkg::CMD_MARK_UNUSED, 16'd1, r);
	endtask

	task automatic test_config_extremes();
		alloc_result_t r;
		// top base, count above storage
		set_config(8'd255, 13'd8191);
		send_request(bba_pkg::CMD_MARK_USED, 16'd255, r);
		send_request(bba_pkg::CMD_FIND, 16'hFFFF, r);
		send_request(bba_pkg::CMD_TEST, 16'd4350, r);
		send_request(bba_pkg::CMD_MARK_USED, 16'd4350, r);
		send_request(bba_pkg::CMD_TEST, 16'd4351, r);
		send_request(bba_pkg::CMD_TEST, 16'd254, r);
		// zero count: nothing in range, nothing to find
		set_config(8'd0, 13'd0);
		send_request(bba_pkg::CMD_FIND, 16'd0, r);
		send_request(bba_pkg::CMD_MARK_USED, 16'd0, r);
		send_request(bba_pkg::CMD_TEST, 16'd0, r);
		// single block
		set_config(8'd0, 13'd1);
		send_request(bba_pkg::CMD_FIND, 16'd0, r);
		send_request(bba_pkg::CMD_MARK_UNUSED, 16'd0, r);
		send_request(bba_pkg::CMD_FIND, 16'd0, r);
		send_request(bba_pkg::CMD_MARK_USED, 16'd0, r);
		send_request(bba_pkg::CMD_FIND, 16'd0, r);
	endtask

	task automatic test_deep_scan();
		alloc_result_t r;
		logic [bba_pkg::BASE_W-1:0] base;
		int k;
		idle_pct = 0;
		stall_pct = 0;
		base = bba_pkg::BASE_W'($urandom);
		set_config(base, bba_pkg::COUNT_W'(FILL_BITS));
		// fill the low words, finds scan ever deeper
		for (int i = 0; i < FILL_BITS; i++) begin
			send_request(bba_pkg::CMD_MARK_USED, bba_pkg::BN_W'(int'(base) + i), r);
			if (i % 64 == 63)
				send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		end
		// first clear bit lies past the count
		send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		// one hole in the top filled word
		k = $urandom_range(FILL_BITS - 1, FILL_BITS - 64);
		send_request(bba_pkg::CMD_MARK_UNUSED, bba_pkg::BN_W'(int'(base) + k), r);
		send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		send_request(bba_pkg::CMD_TEST, bba_pkg::BN_W'(int'(base) + k), r);
		send_request(bba_pkg::CMD_MARK_USED, bba_pkg::BN_W'(int'(base) + k), r);
		set_config(base, 13'd8191);
		send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		// clear downward, finds land ever lower in the filled words
		for (int i = FILL_BITS - 1; i >= 0; i--) begin
			send_request(bba_pkg::CMD_MARK_UNUSED, bba_pkg::BN_W'(int'(base) + i), r);
			if (i % 32 == 0)
				send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
		end
	endtask

	// allocate, free, or a stray request
	task automatic random_sequence();
		alloc_result_t r;
		alloc_result_t r2;
		logic [bba_pkg::BN_W-1:0] bn;
		int pick;
		int idx;
		pick = $urandom_range(99);
		if (pick < 45) begin
			send_request(bba_pkg::CMD_FIND, bba_pkg::BN_W'($urandom), r);
			if (r.status == bba_pkg::STAT_OK) begin
				send_request(bba_pkg::CMD_MARK_USED, r.found_block, r2);
				allocated.push_back(int'(r.found_block));
			end
		end else if (pick < 75) begin
			if (allocated.size() != 0) begin
				idx = $urandom_range(allocated.size() - 1);
				bn = bba_pkg::BN_W'(allocated[idx]);
				allocated.delete(idx);
			end else begin
				bn = edge_number();
			end
			send_request(bba_pkg::CMD_TEST, bn, r);
			send_request(bba_pkg::CMD_MARK_UNUSED, bn, r);
			send_request(bba_pkg::CMD_TEST, bn, r);
		end else begin
			bn = ($urandom_range(1) == 0) ? bba_pkg::BN_W'($urandom) : edge_number();
			send_request(bba_pkg::CMD_W'($urandom_range(3)), bn, r);
		end
	endtask

	task automatic test_random_traffic();
		int idle_set[4];
		int stall_set[4];
		int start;
		idle_set = '{0, 64, 0, 6};
		stall_set = '{0, 0, 64, 6};
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 2; s++) begin
				set_config(pick_base(), pick_count());
				idle_pct = idle_set[p];
				stall_pct = stall_set[p];
				start = requests_sent;
				while (requests_sent - start < BLOCK_ITEMS)
					random_sequence();
			end
		end
	endtask

	// result receiver stalls
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic report_mismatch(input string field, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected none, actual %0d/%0b/%0d",
					$time, rsp_ch.found_block, rsp_ch.is_used, rsp_ch.status);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.found_block !== want.found_block)
					report_mismatch("found_block", want.found_block, rsp_ch.found_block);
				if (rsp_ch.is_used !== want.is_used)
					report_mismatch("is_used", want.is_used, rsp_ch.is_used);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", want.status, rsp_ch.status);
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = bba_pkg::CFG_DATA_BASE;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.command      = bba_pkg::CMD_FIND;
		req_ch.block_number = '0;
		shadow_map          = '0;
		base_reg            = bba_pkg::BASE_RESET;
		count_reg           = bba_pkg::COUNT_RESET;
		idle_pct            = 0;
		stall_pct           = 0;
		errors              = 0;
		requests_sent       = 0;
		finds_sent          = 0;
		results_checked     = 0;
		config_writes       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_config_extremes();
		test_deep_scan();
		test_random_traffic();

		wait_idle(END_CYCLES);
		$display("Sent %0d requests (%0d finds), checked %0d results", requests_sent,
			finds_sent, results_checked);
		$display("Covered %0d register settings, filled low words and four idle/stall mixes",
			config_writes);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
src/bba_pkg.sv
src/bba_req_if.sv
src/bba_rsp_if.sv
src/bba_zero_find.sv
src/block_bitmap_allocator.sv
bench/tb_block_bitmap_allocator.sv
